// ===== hdl/uxc_pkg.sv =====
// Package for the XOR URL codec: shared types, constants and byte helpers.
// Used by uxc_step and url_xor_codec; depends on nothing.
package uxc_pkg;

  localparam int MaxResults = 9;
  localparam int CntW = $clog2(MaxResults + 1);

  localparam logic [7:0] PctChar = 8'h25;
  localparam logic [7:0] TildeChar = 8'h7E;
  localparam logic [7:0] FlipMask = 8'h02;

  typedef enum logic {
    ModeEncode = 1'b0,
    ModeDecode = 1'b1
  } mode_t;

  // Progress of one percent decoder: nothing held, '%' held, '%' and one digit held.
  typedef enum logic [1:0] {
    HoldEmpty = 2'd0,
    HoldPct   = 2'd1,
    HoldDigit = 2'd2
  } hold_t;

  // The first entry of each hold is always '%', so only the digit is kept.
  typedef struct packed {
    logic       odd_position;
    hold_t      first_hold_count;
    logic [7:0] first_hold;
    hold_t      second_hold_count;
    logic [7:0] second_hold;
  } state_t;

  typedef logic [MaxResults-1:0][7:0] res_bytes_t;

  typedef struct packed {
    res_bytes_t      bytes;
    logic [CntW-1:0] count;
    logic            last;
  } result_t;

  function automatic logic plain_byte(input logic [7:0] b);
    return (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A) ||
           (b >= 8'h30 && b <= 8'h39) || b == 8'h2D || b == 8'h5F ||
           b == 8'h2E || b == TildeChar;
  endfunction

  function automatic logic [7:0] hex_digit(input logic [3:0] n);
    return (n < 4'd10) ? (8'h30 + {4'h0, n}) : (8'h37 + {4'h0, n});
  endfunction

  function automatic logic [3:0] hex_value(input logic [7:0] b);
    logic [7:0] v;
    v = 8'h00;
    if (b >= 8'h30 && b <= 8'h39) begin
      v = b - 8'h30;
    end else if (b >= 8'h41 && b <= 8'h46) begin
      v = b - 8'h37;
    end else if (b >= 8'h61 && b <= 8'h66) begin
      v = b - 8'h57;
    end
    return v[3:0];
  endfunction

endpackage

// ===== hdl/uxc_if.sv =====
// Valid/ready channel interfaces for the codec's input and output bytes.
// Standalone; no package needed.
interface uxc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_string;

  modport source (output valid, output in_byte, output end_of_string, input ready);
  modport sink (input valid, input in_byte, input end_of_string, output ready);
endinterface

interface uxc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_string;

  modport source (output valid, output out_byte, output last_of_string, input ready);
  modport sink (input valid, input out_byte, input last_of_string, output ready);
endinterface

// ===== hdl/uxc_step.sv =====
// Single-pass step logic: from one byte and the codec state, the list of
// output bytes and the next state. Depends on uxc_pkg.
module uxc_step import uxc_pkg::*; (
  input  mode_t      mode,
  input  logic [7:0] in_byte,
  input  logic       end_of_string,
  input  state_t     state,
  output state_t     state_next,
  output result_t    result
);

  logic [2:0][7:0] inner;
  logic [1:0]      inner_n;
  logic [7:0]      enc_x;
  res_bytes_t      enc_bytes;
  logic [CntW-1:0] enc_pos;

  logic [2:0][7:0] mid;
  logic [1:0]      mid_n;
  hold_t           fc;
  logic [7:0]      fh;
  hold_t           sc;
  logic [7:0]      sh;
  logic            odd;
  logic [7:0]      dec_y;
  res_bytes_t      dec_bytes;
  logic [CntW-1:0] dec_pos;

  always_comb begin
    inner = '0;
    enc_bytes = '0;
    enc_pos = '0;
    enc_x = '0;
    if (plain_byte(in_byte)) begin
      inner[0] = in_byte;
      inner_n = 2'd1;
    end else begin
      inner[0] = PctChar;
      inner[1] = hex_digit(in_byte[7:4]);
      inner[2] = hex_digit(in_byte[3:0]);
      inner_n = 2'd3;
    end
    for (int k = 0; k < 3; k++) begin
      if (k < int'(inner_n)) begin
        enc_x = inner[k] ^ ((state.odd_position ^ k[0]) ? FlipMask : 8'h00);
        if (plain_byte(enc_x)) begin
          enc_bytes[enc_pos] = enc_x;
          enc_pos = enc_pos + CntW'(1);
        end else begin
          enc_bytes[enc_pos] = PctChar;
          enc_bytes[enc_pos + CntW'(1)] = hex_digit(enc_x[7:4]);
          enc_bytes[enc_pos + CntW'(2)] = hex_digit(enc_x[3:0]);
          enc_pos = enc_pos + CntW'(3);
        end
      end
    end
  end

  always_comb begin
    mid = '0;
    mid_n = 2'd0;
    fc = state.first_hold_count;
    fh = state.first_hold;
    sc = state.second_hold_count;
    sh = state.second_hold;
    odd = state.odd_position;
    dec_y = '0;
    dec_bytes = '0;
    dec_pos = '0;

    unique case (fc)
      HoldEmpty: begin
        if (in_byte == PctChar) begin
          fc = HoldPct;
        end else begin
          mid[0] = in_byte;
          mid_n = 2'd1;
        end
      end
      HoldPct: begin
        fh = in_byte;
        fc = HoldDigit;
      end
      HoldDigit: begin
        mid[0] = {hex_value(fh), hex_value(in_byte)};
        mid_n = 2'd1;
        fc = HoldEmpty;
      end
      default: fc = HoldEmpty;
    endcase

    if (end_of_string) begin
      if (fc != HoldEmpty) begin
        mid[mid_n] = PctChar;
        mid_n = mid_n + 2'd1;
      end
      if (fc == HoldDigit) begin
        mid[mid_n] = fh;
        mid_n = mid_n + 2'd1;
      end
    end

    for (int k = 0; k < 3; k++) begin
      if (k < int'(mid_n)) begin
        dec_y = mid[k] ^ (odd ? FlipMask : 8'h00);
        odd = ~odd;
        unique case (sc)
          HoldEmpty: begin
            if (dec_y == PctChar) begin
              sc = HoldPct;
            end else begin
              dec_bytes[dec_pos] = dec_y;
              dec_pos = dec_pos + CntW'(1);
            end
          end
          HoldPct: begin
            sh = dec_y;
            sc = HoldDigit;
          end
          HoldDigit: begin
            dec_bytes[dec_pos] = {hex_value(sh), hex_value(dec_y)};
            dec_pos = dec_pos + CntW'(1);
            sc = HoldEmpty;
          end
          default: sc = HoldEmpty;
        endcase
      end
    end

    if (end_of_string) begin
      if (sc != HoldEmpty) begin
        dec_bytes[dec_pos] = PctChar;
        dec_pos = dec_pos + CntW'(1);
      end
      if (sc == HoldDigit) begin
        dec_bytes[dec_pos] = sh;
        dec_pos = dec_pos + CntW'(1);
      end
    end
  end

  always_comb begin
    state_next = state;
    result.last = end_of_string;
    if (mode == ModeEncode) begin
      result.bytes = enc_bytes;
      result.count = enc_pos;
      state_next.odd_position = ~state.odd_position;
    end else begin
      result.bytes = dec_bytes;
      result.count = dec_pos;
      state_next.odd_position = odd;
      state_next.first_hold_count = fc;
      state_next.first_hold = fh;
      state_next.second_hold_count = sc;
      state_next.second_hold = sh;
    end
    if (end_of_string) begin
      state_next.odd_position = 1'b0;
      state_next.first_hold_count = HoldEmpty;
      state_next.second_hold_count = HoldEmpty;
    end
  end

endmodule

// ===== hdl/url_xor_codec.sv =====
// Top level of the XOR URL codec: request register, step logic, output buffer.
// Depends on uxc_pkg, uxc_in_if, uxc_out_if and uxc_step.
//
// Requests arrive on the text channel, one byte each, with end_of_string on
// the final byte of a string. Coded bytes leave on the coded channel, with
// last_of_string on the final output byte of a string. The mode register is
// written through cfg_we and cfg_data: 0 encodes, 1 decodes.
// A request is held in an input register, then its whole output list (up to
// nine bytes) is computed at once into a shift buffer that drains one byte
// per cycle while the receiver is ready. The first output byte is shown
// once the request has passed the input register into the buffer. A request
// whose output is one byte sustains one request per cycle while the receiver
// is ready; otherwise the next request waits while the buffer drains.
// A request may be accepted while the buffer still holds bytes; the input
// register waits until the buffer shows its final byte being taken.
// When the receiver stalls, the buffer holds and the input register fills,
// then ready drops. Reset (synchronous, active high) empties both registers,
// clears the codec state and sets encode mode.
module url_xor_codec import uxc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      cfg_we,
  input  logic      cfg_data,
  uxc_in_if.sink    text,
  uxc_out_if.source coded
);

  mode_t           mode;
  logic            held_valid;
  logic [7:0]      held_byte;
  logic            held_end;
  state_t          state;
  state_t          state_next;
  result_t         result;
  res_bytes_t      buf_bytes;
  logic [CntW-1:0] buf_count;
  logic            buf_last;
  logic            pop;
  logic            load;

  uxc_step u_step (
    .mode          (mode),
    .in_byte       (held_byte),
    .end_of_string (held_end),
    .state         (state),
    .state_next    (state_next),
    .result        (result)
  );

  assign pop = coded.valid && coded.ready;
  assign load = held_valid &&
                ((buf_count == '0) || ((buf_count == CntW'(1)) && pop));

  assign text.ready = !held_valid || load;
  assign coded.valid = (buf_count != '0);
  assign coded.out_byte = buf_bytes[0];
  assign coded.last_of_string = buf_last && (buf_count == CntW'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= ModeEncode;
      held_valid <= 1'b0;
      state <= '0;
      buf_count <= '0;
    end else begin
      if (cfg_we) begin
        mode <= mode_t'(cfg_data);
      end
      if (text.valid && text.ready) begin
        held_valid <= 1'b1;
      end else if (load) begin
        held_valid <= 1'b0;
      end
      if (load) begin
        state <= state_next;
        buf_count <= result.count;
      end else if (pop) begin
        buf_count <= buf_count - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (text.valid && text.ready) begin
      held_byte <= text.in_byte;
      held_end <= text.end_of_string;
    end
    if (load) begin
      buf_bytes <= result.bytes;
      buf_last <= result.last;
    end else if (pop) begin
      buf_bytes <= res_bytes_t'(buf_bytes >> 8);
    end
  end

endmodule

// ===== hdl/uxc_chk.sv =====
// Port-level checker for the XOR URL codec, bound to the top level.
// Depends only on the top level's ports.
module uxc_chk (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       out_last
);

  a_reset_empties: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("Output valid after reset.");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
      out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_last))
    else $error("Stalled output changed.");

  a_backpressure_cause: assert property (@(posedge clk) disable iff (rst)
      !in_ready |-> out_valid)
    else $error("Input stalled while no output is pending.");

  a_drain_by_pop: assert property (@(posedge clk) disable iff (rst)
      $fell(out_valid) && !$past(rst) |-> $past(out_valid && out_ready))
    else $error("Output dropped without being taken.");

endmodule

bind url_xor_codec uxc_chk u_chk (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (text.valid),
  .in_ready  (text.ready),
  .out_valid (coded.valid),
  .out_ready (coded.ready),
  .out_byte  (coded.out_byte),
  .out_last  (coded.last_of_string)
);
